### sv/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, character codes and the request and result types shared
// by the console writer and its testbench.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry and tab spacing.
    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int TAB_STOP      = 8;

    // Derived sizes.
    localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
    localparam int REM_W  = $clog2(TAB_STOP) + 1;
    localparam int CELL_W = 16;

    // Character codes, the cursor marker attribute and the reset attribute.
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_MARK    = 8'h5F;
    localparam logic [7:0] CH_BLANK   = 8'h20;
    localparam logic [7:0] MARK_ATTR  = 8'h00;
    localparam logic [7:0] ATTR_RESET = 8'h07;

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_PUT    = 2'd0,
        KIND_CURSOR = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    // One request.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_code;
        logic [6:0] col;
        logic [4:0] line;
    } t_item;

    // One result.
    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [6:0] cursor_col;
        logic [4:0] cursor_line;
        logic       scrolled;
    } t_result;

endpackage
`default_nettype wire

### sv/tcw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### sv/text_console_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer
// Character-and-attribute text screen with a print offset, scrolling, a
// cursor marker, screen clear and cell read-back.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. Each
//   request gives one result on o_result, shown for one cycle with
//   o_res_valid high; the receiver cannot stall it.
//   The attribute register is written through i_cfg_valid / i_cfg_data,
//   always ready; write it only while the block is idle.
// Request handling (the screen store has one write and one read port):
//   ordinary byte or newline: result in the next cycle, back to back.
//   read cell: the cell is read into S_READ, then the result is registered.
//   tab: S_TSTEP steps one cell at a time up to the next tab stop.
//   set cursor: a linear scan for the old marker (S_SCAN), then S_MARK.
//   clear: S_CLEAR blanks every cell, then S_MARK marks the home cell.
//   a scroll adds a row copy and blanking pass (S_SCROLL); busy stays high.
// Reset:
//   After reset a clearing pass over all CELLS cells (2000 at 80 x 25) zeroes
//   the screen store; busy stays high meanwhile. Attribute writes are taken.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_item      i_item,
    output logic            o_res_valid,
    output t_result         o_result,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SCAN,
        S_MARK,
        S_CLEAR,
        S_SCROLL,
        S_TSTEP
    } t_state;

    t_state                r_state, n_state;
    logic [ADDR_W-1:0]     r_idx, n_idx;
    logic [COL_W-1:0]      r_col, n_col;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [COL_W-1:0]      r_tcol, n_tcol;
    logic [ROW_W-1:0]      r_trow, n_trow;
    logic [7:0]            r_attr, n_attr;
    logic [REM_W-1:0]      r_tab, n_tab;
    t_result               r_res, n_res;
    logic                  r_res_vld, n_res_vld;

    // Screen store port signals.
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [CELL_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [CELL_W-1:0]     ram_rdata;

    // Derived position values.
    logic [COL_W-1:0]      adv_col;
    logic [ROW_W-1:0]      adv_row;
    logic                  adv_ovf;
    logic                  nl_ovf;
    logic [ROW_W-1:0]      nl_row;
    logic [ADDR_W-1:0]     cur_addr;
    logic [COL_W-1:0]      clamp_col;
    logic [ROW_W-1:0]      clamp_row;
    logic [ADDR_W:0]       scroll_rd;

    // Linear cell address of a row and column.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col);
    endfunction

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Advance by one cell, and the start of the next row for a newline.
    always_comb begin
        nl_ovf = (r_row == ROW_W'(SCREEN_HEIGHT - 1));
        nl_row = r_row + ROW_W'(1);
        if (r_col == COL_W'(SCREEN_WIDTH - 1)) begin
            adv_col = '0;
            adv_row = nl_row;
            adv_ovf = nl_ovf;
        end else begin
            adv_col = r_col + COL_W'(1);
            adv_row = r_row;
            adv_ovf = 1'b0;
        end
    end

    // Coordinates of a request, clamped to the screen.
    always_comb begin
        clamp_col = (32'(i_item.col) > 32'(SCREEN_WIDTH - 1)) ?
                    COL_W'(SCREEN_WIDTH - 1) : COL_W'(i_item.col);
        clamp_row = (32'(i_item.line) > 32'(SCREEN_HEIGHT - 1)) ?
                    ROW_W'(SCREEN_HEIGHT - 1) : ROW_W'(i_item.line);
    end

    // Offset and scroll source address.
    always_comb begin
        cur_addr  = cell_addr(r_row, r_col);
        scroll_rd = {1'b0, r_idx} + (ADDR_W + 1)'(SCREEN_WIDTH + 1);
    end

    // Sequencer next-state logic.
    always_comb begin
        logic             do_scroll;
        logic             do_finish;
        logic [COL_W-1:0] f_col;
        logic [ROW_W-1:0] f_row;
        logic             f_scr;
        logic [7:0]       f_char;
        logic [7:0]       f_attr;

        do_scroll = 1'b0;
        do_finish = 1'b0;
        f_col     = r_col;
        f_row     = r_row;
        f_scr     = 1'b0;
        f_char    = '0;
        f_attr    = '0;

        n_state   = r_state;
        n_idx     = r_idx;
        n_col     = r_col;
        n_row     = r_row;
        n_tcol    = r_tcol;
        n_trow    = r_trow;
        n_attr    = (i_cfg_valid) ? i_cfg_data : r_attr;
        n_tab     = r_tab;
        n_res     = r_res;
        n_res_vld = 1'b0;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        unique case (r_state)
            // Zero the screen store after reset.
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = '0;
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end

            // Take a request and start its work.
            S_IDLE: begin
                if (start) begin
                    unique case (i_item.kind)
                        KIND_PUT: begin
                            priority if (i_item.char_code == CH_NEWLINE) begin
                                f_col = '0;
                                f_row = nl_row;
                                if (nl_ovf) begin
                                    do_scroll = 1'b1;
                                end else begin
                                    do_finish = 1'b1;
                                end
                            end else if (i_item.char_code == CH_TAB) begin
                                // The tab spacing is a power of two, so the
                                // remainder is the low offset bits.
                                n_tab   = REM_W'(TAB_STOP) -
                                          REM_W'(32'(cur_addr) % TAB_STOP);
                                n_state = S_TSTEP;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = cur_addr;
                                ram_wdata = {i_item.char_code, r_attr};
                                f_col     = adv_col;
                                f_row     = adv_row;
                                if (adv_ovf) begin
                                    do_scroll = 1'b1;
                                end else begin
                                    do_finish = 1'b1;
                                end
                            end
                        end
                        KIND_CURSOR: begin
                            n_tcol    = clamp_col;
                            n_trow    = clamp_row;
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_idx     = '0;
                            n_state   = S_SCAN;
                        end
                        KIND_CLEAR: begin
                            n_tcol  = '0;
                            n_trow  = '0;
                            n_idx   = '0;
                            n_state = S_CLEAR;
                        end
                        KIND_READ: begin
                            ram_re    = 1'b1;
                            ram_raddr = cell_addr(clamp_row, clamp_col);
                            n_state   = S_READ;
                        end
                    endcase
                end
            end

            // Return the cell that was read.
            S_READ: begin
                f_char    = ram_rdata[15:8];
                f_attr    = ram_rdata[7:0];
                do_finish = 1'b1;
            end

            // Look for the old marker and blank it.
            S_SCAN: begin
                if (ram_rdata == {CH_MARK, MARK_ATTR}) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx;
                    ram_wdata = {CH_BLANK, r_attr};
                    n_state   = S_MARK;
                end else if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_state = S_MARK;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx + ADDR_W'(1);
                    n_idx     = r_idx + ADDR_W'(1);
                end
            end

            // Place the new marker and move the offset to it.
            S_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(r_trow, r_tcol);
                ram_wdata = {CH_MARK, MARK_ATTR};
                f_col     = r_tcol;
                f_row     = r_trow;
                do_finish = 1'b1;
            end

            // Blank the whole screen; the marker goes to the home cell.
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = {CH_BLANK, r_attr};
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_state = S_MARK;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end

            // Copy each cell up one row, then blank the last row.
            S_SCROLL: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                if (32'(r_idx) >= CELLS - SCREEN_WIDTH) begin
                    ram_wdata = {CH_BLANK, r_attr};
                end else begin
                    ram_wdata = ram_rdata;
                end
                if (scroll_rd < (ADDR_W + 1)'(CELLS)) begin
                    ram_re    = 1'b1;
                    ram_raddr = scroll_rd[ADDR_W-1:0];
                end
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    f_col     = '0;
                    f_row     = ROW_W'(SCREEN_HEIGHT - 1);
                    f_scr     = 1'b1;
                    do_finish = 1'b1;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end

            // Step the offset to the tab stop one cell at a time.
            S_TSTEP: begin
                f_col = adv_col;
                f_row = adv_row;
                if (adv_ovf) begin
                    do_scroll = 1'b1;
                end else if (r_tab == REM_W'(1)) begin
                    do_finish = 1'b1;
                end else begin
                    n_col = adv_col;
                    n_row = adv_row;
                    n_tab = r_tab - REM_W'(1);
                end
            end
        endcase

        // Start a scroll: prime the read of the first source row.
        if (do_scroll) begin
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(SCREEN_WIDTH);
            n_idx     = '0;
            n_state   = S_SCROLL;
        end

        // Issue the result and go back to idle.
        if (do_finish) begin
            n_col                 = f_col;
            n_row                 = f_row;
            n_res.cell_char       = f_char;
            n_res.cell_attr       = f_attr;
            n_res.cursor_col      = 7'(f_col);
            n_res.cursor_line     = 5'(f_row);
            n_res.scrolled        = f_scr;
            n_res_vld             = 1'b1;
            n_state               = S_IDLE;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_idx     <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_attr    <= ATTR_RESET;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_col     <= n_col;
            r_row     <= n_row;
            r_attr    <= n_attr;
            r_res_vld <= n_res_vld;
        end
        r_tcol <= n_tcol;
        r_trow <= n_trow;
        r_tab  <= n_tab;
        r_res  <= n_res;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_vld;
    assign o_result    = r_res;
    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire

### sim/text_console_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put, set-cursor, clear and read requests with bursty start timing,
// keeps a shadow screen, print position and attribute register, and checks
// every result field against the shadow or a typed one, for several attributes.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
    import tcw_pkg::*;

    // One row of the directed table; want is used only when fixed is set.
    typedef struct {
        t_item   it;
        bit      fixed;
        t_result want;
    } t_step;

    logic    i_clk;
    logic    i_rst_n     = 1'b0;
    logic    start       = 1'b0;
    logic    busy;
    t_item   i_item      = '0;
    logic    o_res_valid;
    t_result o_result;
    logic    i_cfg_valid = 1'b0;
    logic    o_cfg_ready;
    logic [7:0] i_cfg_data = '0;

    // Shadow of the screen store, the print position and the attribute.
    logic [7:0] shadow_chars [CELLS];
    logic [7:0] shadow_attrs [CELLS];
    int         shadow_pos      = 0;
    logic [7:0] shadow_attr_reg = ATTR_RESET;

    t_result pending_results[$];
    bit      fixed_valid   = 1'b0;
    t_result fixed_result  = '0;
    int      n_taken       = 0;
    int      n_attr_writes = 0;
    int      errors        = 0;

    text_console_writer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Erase the first marker cell, if any, and place a new one at (c, l).
    function automatic void move_marker(int c, int l);
        int i;
        for (i = 0; i < CELLS; i++) begin
            if (shadow_chars[i] == CH_MARK && shadow_attrs[i] == MARK_ATTR) begin
                shadow_chars[i] = CH_BLANK;
                shadow_attrs[i] = shadow_attr_reg;
                break;
            end
        end
        shadow_pos = l * SCREEN_WIDTH + c;
        shadow_chars[shadow_pos] = CH_MARK;
        shadow_attrs[shadow_pos] = MARK_ATTR;
    endfunction

    // Apply one request to the shadow screen and return the result it gives.
    function automatic t_result console_apply(t_item it);
        int      c;
        int      l;
        int      i;
        t_result r;
        r = '0;
        c = (it.col > SCREEN_WIDTH - 1) ? SCREEN_WIDTH - 1 : int'(it.col);
        l = (it.line > SCREEN_HEIGHT - 1) ? SCREEN_HEIGHT - 1 : int'(it.line);
        case (it.kind)
            KIND_PUT: begin
                if (it.char_code == CH_NEWLINE) begin
                    shadow_pos += SCREEN_WIDTH - shadow_pos % SCREEN_WIDTH;
                end else if (it.char_code == CH_TAB) begin
                    shadow_pos += TAB_STOP - shadow_pos % TAB_STOP;
                end else begin
                    shadow_chars[shadow_pos] = it.char_code;
                    shadow_attrs[shadow_pos] = shadow_attr_reg;
                    shadow_pos++;
                end
                // Past the last cell: move every row up and blank the last one.
                if (shadow_pos >= CELLS) begin
                    for (i = 0; i < CELLS - SCREEN_WIDTH; i++) begin
                        shadow_chars[i] = shadow_chars[i + SCREEN_WIDTH];
                        shadow_attrs[i] = shadow_attrs[i + SCREEN_WIDTH];
                    end
                    for (i = CELLS - SCREEN_WIDTH; i < CELLS; i++) begin
                        shadow_chars[i] = CH_BLANK;
                        shadow_attrs[i] = shadow_attr_reg;
                    end
                    shadow_pos = CELLS - SCREEN_WIDTH;
                    r.scrolled = 1'b1;
                end
            end
            KIND_CURSOR: begin
                move_marker(c, l);
            end
            KIND_CLEAR: begin
                for (i = 0; i < CELLS; i++) begin
                    shadow_chars[i] = CH_BLANK;
                    shadow_attrs[i] = shadow_attr_reg;
                end
                move_marker(0, 0);
            end
            default: begin
                r.cell_char = shadow_chars[l * SCREEN_WIDTH + c];
                r.cell_attr = shadow_attrs[l * SCREEN_WIDTH + c];
            end
        endcase
        r.cursor_col  = 7'(shadow_pos % SCREEN_WIDTH);
        r.cursor_line = 5'(shadow_pos / SCREEN_WIDTH);
        return r;
    endfunction

    // Directed rows: one checked against the shadow, one with a typed result.
    function automatic t_step plain(t_kind k, logic [7:0] ch, logic [6:0] c,
                                    logic [4:0] l);
        t_step s;
        s.it    = '{kind: k, char_code: ch, col: c, line: l};
        s.fixed = 1'b0;
        s.want  = '0;
        return s;
    endfunction

    function automatic t_step known(t_kind k, logic [7:0] ch, logic [6:0] c,
                                    logic [4:0] l, logic [7:0] rc, logic [7:0] ra,
                                    logic [6:0] cc, logic [4:0] cl, logic sc);
        t_step s;
        s       = plain(k, ch, c, l);
        s.fixed = 1'b1;
        s.want  = '{cell_char: rc, cell_attr: ra, cursor_col: cc,
                    cursor_line: cl, scrolled: sc};
        return s;
    endfunction

    // Field-by-field comparison of one result.
    task automatic compare_result(t_result got, t_result want);
        if (got.cell_char !== want.cell_char) begin
            $error("cell_char: expected %0d, got %0d", want.cell_char, got.cell_char);
            errors++;
        end
        if (got.cell_attr !== want.cell_attr) begin
            $error("cell_attr: expected %0d, got %0d", want.cell_attr, got.cell_attr);
            errors++;
        end
        if (got.cursor_col !== want.cursor_col) begin
            $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
            errors++;
        end
        if (got.cursor_line !== want.cursor_line) begin
            $error("cursor_line: expected %0d, got %0d", want.cursor_line,
                   got.cursor_line);
            errors++;
        end
        if (got.scrolled !== want.scrolled) begin
            $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
            errors++;
        end
    endtask

    // Monitor: check results, track attribute writes and accepted requests.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_res_valid === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request pending");
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    compare_result(o_result, want);
                end
            end
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                shadow_attr_reg = i_cfg_data;
                n_attr_writes++;
            end
            if (start && busy === 1'b0) begin
                want = console_apply(i_item);
                if (fixed_valid)
                    want = fixed_result;
                pending_results.push_back(want);
                n_taken++;
            end
        end
    end

    // Present one request from a falling edge and hold it until accepted.
    task automatic issue(t_item it, bit has_fixed, t_result fixed);
        int target;
        target       = n_taken + 1;
        fixed_valid  = has_fixed;
        fixed_result = fixed;
        start  <= 1'b1;
        i_item <= it;
        do @(negedge i_clk); while (n_taken < target);
    endtask

    task automatic pause(int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Stop sending and wait until every result is in and the block is free.
    task automatic wait_idle();
        pause(1);
        while (pending_results.size() != 0 || busy !== 1'b0)
            @(negedge i_clk);
    endtask

    task automatic write_attr(logic [7:0] value);
        int target;
        target = n_attr_writes + 1;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (n_attr_writes < target);
        i_cfg_valid <= 1'b0;
    endtask

    // Stimulus: directed table, then random phases under different attributes.
    initial begin
        t_step      steps[$];
        t_item      it;
        logic [7:0] phase_attr [6];
        int         burst;
        int         pick;
        int         row;

        foreach (shadow_chars[i]) begin
            shadow_chars[i] = '0;
            shadow_attrs[i] = '0;
        end

        // Fresh screen, attribute 7, print position at the home cell.
        steps.push_back(known(KIND_READ, 8'h00, 7'd0, 5'd0, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0));
        steps.push_back(known(KIND_READ, 8'hA5, 7'd127, 5'd31,
                              8'h00, 8'h00, 7'd0, 5'd0, 1'b0));
        // Printable byte, the zero byte, the top byte, tab and newline.
        steps.push_back(known(KIND_PUT, 8'h41, 7'd0, 5'd0, 8'h00, 8'h00, 7'd1, 5'd0, 1'b0));
        steps.push_back(known(KIND_PUT, 8'h00, 7'd0, 5'd0, 8'h00, 8'h00, 7'd2, 5'd0, 1'b0));
        steps.push_back(known(KIND_PUT, 8'hFF, 7'd0, 5'd0, 8'h00, 8'h00, 7'd3, 5'd0, 1'b0));
        steps.push_back(known(KIND_PUT, CH_TAB, 7'd0, 5'd0, 8'h00, 8'h00, 7'd8, 5'd0, 1'b0));
        steps.push_back(known(KIND_PUT, CH_NEWLINE, 7'd0, 5'd0,
                              8'h00, 8'h00, 7'd0, 5'd1, 1'b0));
        steps.push_back(known(KIND_READ, 8'h5A, 7'd0, 5'd0, 8'h41, 8'h07, 7'd0, 5'd1, 1'b0));
        // Clamped cursor with no marker present, then a print into the last cell.
        steps.push_back(known(KIND_CURSOR, 8'h00, 7'd127, 5'd31,
                              8'h00, 8'h00, 7'd79, 5'd24, 1'b0));
        steps.push_back(known(KIND_PUT, 8'h42, 7'd0, 5'd0, 8'h00, 8'h00, 7'd0, 5'd24, 1'b1));
        steps.push_back(known(KIND_READ, 8'h00, 7'd79, 5'd23,
                              8'h42, 8'h07, 7'd0, 5'd24, 1'b0));
        steps.push_back(known(KIND_READ, 8'h00, 7'd0, 5'd24,
                              CH_BLANK, 8'h07, 7'd0, 5'd24, 1'b0));
        // Marker placed, then moved: the old one is blanked.
        steps.push_back(plain(KIND_CURSOR, 8'h00, 7'd5, 5'd3));
        steps.push_back(plain(KIND_CURSOR, 8'h00, 7'd10, 5'd10));
        steps.push_back(plain(KIND_READ, 8'h00, 7'd5, 5'd3));
        // Clear leaves a marker at home.
        steps.push_back(known(KIND_CLEAR, 8'hC3, 7'd0, 5'd0, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0));
        steps.push_back(known(KIND_READ, 8'h00, 7'd0, 5'd0,
                              CH_MARK, MARK_ATTR, 7'd0, 5'd0, 1'b0));
        steps.push_back(plain(KIND_READ, 8'h00, 7'd79, 5'd24));
        // Tab carrying into the next row, and tab and newline off the screen end.
        steps.push_back(plain(KIND_CURSOR, 8'h00, 7'd78, 5'd5));
        steps.push_back(plain(KIND_PUT, CH_TAB, 7'd0, 5'd0));
        steps.push_back(plain(KIND_CURSOR, 8'h00, 7'd75, 5'd24));
        steps.push_back(plain(KIND_PUT, CH_TAB, 7'd0, 5'd0));
        steps.push_back(plain(KIND_PUT, CH_NEWLINE, 7'd0, 5'd0));
        steps.push_back(plain(KIND_CURSOR, 8'h00, 7'd0, 5'd31));
        steps.push_back(plain(KIND_READ, 8'h00, 7'd127, 5'd0));

        // Reset, then let the clearing pass finish.
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();
        write_attr(ATTR_RESET);

        foreach (steps[k]) begin
            issue(steps[k].it, steps[k].fixed, steps[k].want);
            if ($urandom_range(0, 3) == 0)
                pause($urandom_range(1, 6));
        end

        phase_attr[0] = 8'h00;
        phase_attr[1] = 8'hFF;
        phase_attr[2] = 8'($urandom_range(0, 255));
        phase_attr[3] = 8'h00;
        phase_attr[4] = 8'h80;
        phase_attr[5] = 8'($urandom_range(0, 255));

        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            write_attr(phase_attr[phase]);
            burst = $urandom_range(1, 40);
            for (int n = 0; n < 190; n++) begin
                // Mostly prints; scans, scrolls and clears are kept rarer.
                pick = $urandom_range(0, 99);
                if (pick < 66)
                    it.kind = KIND_PUT;
                else if (pick < 76)
                    it.kind = KIND_CURSOR;
                else if (pick < 77)
                    it.kind = KIND_CLEAR;
                else
                    it.kind = KIND_READ;
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    it.char_code = CH_NEWLINE;
                else if (pick < 16)
                    it.char_code = CH_TAB;
                else if (pick < 26)
                    it.char_code = CH_MARK;
                else if (pick < 30)
                    it.char_code = CH_BLANK;
                else
                    it.char_code = 8'($urandom_range(0, 255));
                it.col  = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(80, 127))
                                                      : 7'($urandom_range(0, 79));
                it.line = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(25, 31))
                                                      : 5'($urandom_range(0, 24));
                // Half the reads look at the rows just printed.
                if (it.kind == KIND_READ && $urandom_range(0, 1) == 1) begin
                    row = shadow_pos / SCREEN_WIDTH - $urandom_range(0, 1);
                    it.line = 5'((row < 0) ? 0 : row);
                end
                issue(it, 1'b0, '0);
                burst--;
                if (burst == 0) begin
                    pause($urandom_range(1, 12));
                    burst = $urandom_range(1, 40);
                end
            end
        end

        // Drain, then keep the clock running and check that no result is still owed.
        wait_idle();
        repeat (4100) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: 200 ms, far beyond the slowest legal run.
    initial begin
        #200_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
